// File: design/rv32im_integer_alu_assert.svh
// assertion macros for the rv32im alu
// used by the alu top level, no other dependencies
`ifndef RV32IM_INTEGER_ALU_ASSERT_SVH
`define RV32IM_INTEGER_ALU_ASSERT_SVH
`define RIA_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define RIA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: design/ria_pkg.sv
// shared types, operation codes and constants for the rv32im alu
// no dependencies
package ria_pkg;
  localparam int DIV_STAGES = 32;

  typedef enum logic [4:0] {
    OP_PASSB = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_SLT = 5'd3, OP_SLTU = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_SLL = 5'd8, OP_SRL = 5'd9,
    OP_SRA = 5'd10, OP_MUL = 5'd11, OP_MULH = 5'd12, OP_DIV = 5'd13,
    OP_DIVU = 5'd14, OP_REM = 5'd15, OP_REMU = 5'd16
  } op_t;

  typedef struct packed {
    logic [4:0]  func;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [4:0]  dest_reg;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic [4:0]  dest_index;
  } out_t;

  // item moving through the division cell row
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        neg_q;
    logic        neg_r;
    logic        special;
    logic [31:0] special_val;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic [4:0]  dest;
  } cell_t;
endpackage

// File: design/rv32im_integer_alu.sv
// rv32im execute unit top level: simple ops, multiplier and division cell row
// depends on ria_pkg, ria_div_cell and rv32im_integer_alu_assert.svh
//
// usage:
//   input channel in_valid/in_stall carries func, operands and dest_reg;
//   output channel out_valid/out_stall carries result and dest_index.
//   every item passes through a fixed pipeline of 34 register stages: one
//   entry register, 32 division cells (one quotient bit each), one result
//   register. all operations take the same path so order is kept.
//   throughput is one transaction per cycle unless the receiver stalls.
//   when the receiver stalls with a result waiting, the whole pipeline
//   freezes and in_stall follows out_stall; no item is lost.
//   reset clears every valid bit; payload registers are not reset.
//   no state persists between items.
`include "rv32im_integer_alu_assert.svh"
module rv32im_integer_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ria_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ria_pkg::out_t out_data
);
  logic en;
  ria_pkg::cell_t row [0:ria_pkg::DIV_STAGES];
  logic [63:0] prod_s [0:ria_pkg::DIV_STAGES];
  logic [31:0] simple [0:ria_pkg::DIV_STAGES];
  logic [4:0]  fn     [0:ria_pkg::DIV_STAGES];
  logic [31:0] a, b, ma, mb, simple_v, q, r;
  logic [63:0] prod;
  logic [4:0] sh;
  logic sdiv;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign a = in_data.operand_a;
  assign b = in_data.operand_b;
  assign sh = b[4:0];
  assign sdiv = in_data.func == ria_pkg::OP_DIV || in_data.func == ria_pkg::OP_REM;
  assign ma = (sdiv && a[31]) ? -a : a;
  assign mb = (sdiv && b[31]) ? -b : b;

  always_comb begin
    case (in_data.func)
      ria_pkg::OP_PASSB: simple_v = b;
      ria_pkg::OP_ADD:   simple_v = a + b;
      ria_pkg::OP_SUB:   simple_v = a - b;
      ria_pkg::OP_SLT:   simple_v = {31'd0, $signed(a) < $signed(b)};
      ria_pkg::OP_SLTU:  simple_v = {31'd0, a < b};
      ria_pkg::OP_AND:   simple_v = a & b;
      ria_pkg::OP_OR:    simple_v = a | b;
      ria_pkg::OP_XOR:   simple_v = a ^ b;
      ria_pkg::OP_SLL:   simple_v = a << sh;
      ria_pkg::OP_SRL:   simple_v = a >> sh;
      ria_pkg::OP_SRA:   simple_v = $unsigned($signed(a) >>> sh);
      default:           simple_v = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0].valid <= 1'b0;
    end else if (en) begin
      row[0].valid <= in_valid;
    end
    if (en) begin
      row[0].is_div <= in_data.func == ria_pkg::OP_DIV || in_data.func == ria_pkg::OP_DIVU;
      row[0].neg_q <= sdiv && (a[31] ^ b[31]);
      row[0].neg_r <= sdiv && a[31];
      row[0].special <= b == 32'd0;
      row[0].special_val <= (in_data.func == ria_pkg::OP_DIV ||
                             in_data.func == ria_pkg::OP_DIVU) ? 32'hffff_ffff : a;
      row[0].rem <= 32'd0;
      row[0].quo <= ma;
      row[0].dvs <= mb;
      row[0].dest <= in_data.dest_reg;
      simple[0] <= simple_v;
      fn[0] <= in_data.func;
      prod_s[0] <= $signed({a[31] & (in_data.func == ria_pkg::OP_MULH), a}) *
                   $signed({b[31] & (in_data.func == ria_pkg::OP_MULH), b});
    end
  end

  genvar i;
  generate
    for (i = 0; i < ria_pkg::DIV_STAGES; i++) begin : g_cell
      ria_div_cell u_cell (.clk(clk), .rst(rst), .en(en), .prev(row[i]), .cur(row[i+1]));
      always_ff @(posedge clk) begin
        if (en) begin
          simple[i+1] <= simple[i];
          fn[i+1] <= fn[i];
          prod_s[i+1] <= prod_s[i];
        end
      end
    end
  endgenerate

  assign prod = prod_s[ria_pkg::DIV_STAGES];
  assign q = row[ria_pkg::DIV_STAGES].neg_q ? -row[ria_pkg::DIV_STAGES].quo
                                            : row[ria_pkg::DIV_STAGES].quo;
  assign r = row[ria_pkg::DIV_STAGES].neg_r ? -row[ria_pkg::DIV_STAGES].rem
                                            : row[ria_pkg::DIV_STAGES].rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= row[ria_pkg::DIV_STAGES].valid;
    end
    if (en) begin
      out_data.dest_index <= row[ria_pkg::DIV_STAGES].dest;
      case (fn[ria_pkg::DIV_STAGES])
        ria_pkg::OP_MUL:  out_data.result <= prod[31:0];
        ria_pkg::OP_MULH: out_data.result <= prod[63:32];
        ria_pkg::OP_DIV, ria_pkg::OP_DIVU, ria_pkg::OP_REM, ria_pkg::OP_REMU:
          out_data.result <= row[ria_pkg::DIV_STAGES].special ?
                             row[ria_pkg::DIV_STAGES].special_val :
                             (row[ria_pkg::DIV_STAGES].is_div ? q : r);
        default:          out_data.result <= simple[ria_pkg::DIV_STAGES];
      endcase
    end
  end

  `RIA_ASSERT_IMPL(a_stall_follows, clk, rst, out_valid && out_stall, in_stall)
  `RIA_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `RIA_ASSERT_NEXT(a_entry_flow, clk, rst, in_valid && !in_stall, row[0].valid)
endmodule

// File: design/ria_div_cell.sv
// one restoring-division step cell, registered, passes item to its neighbor
// depends on ria_pkg
module ria_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ria_pkg::cell_t prev,
  output ria_pkg::cell_t cur
);
  logic [32:0] trial;
  logic [31:0] shrem;
  ria_pkg::cell_t nxt;

  always_comb begin
    nxt = prev;
    shrem = {prev.rem[30:0], prev.quo[31]};
    trial = {prev.rem, prev.quo[31]} - {1'b0, prev.dvs};
    nxt.quo = {prev.quo[30:0], ~trial[32]};
    nxt.rem = trial[32] ? shrem : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= prev.valid;
    end
    if (en) begin
      cur.is_div <= nxt.is_div;
      cur.neg_q <= nxt.neg_q;
      cur.neg_r <= nxt.neg_r;
      cur.special <= nxt.special;
      cur.special_val <= nxt.special_val;
      cur.rem <= nxt.rem;
      cur.quo <= nxt.quo;
      cur.dvs <= nxt.dvs;
      cur.dest <= nxt.dest;
    end
  end
endmodule
